// File: sv/ps2_mouse_packet_cursor_top_assert.svh
// assertion macros shared by the ps2 mouse cursor modules
// each expects clk_i and rst_ni in the scope where it is used
`ifndef PS2_MOUSE_PACKET_CURSOR_TOP_ASSERT_SVH
`define PS2_MOUSE_PACKET_CURSOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock outside reset
`define PS2MPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define PS2MPC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define PS2MPC_ASSERT(lbl, prop, msg)
`define PS2MPC_NEVER(lbl, cond, msg)

`endif

`endif

// File: sv/ps2mpc_pkg.sv
package ps2mpc_pkg;

  // register reset values and cursor home position
  localparam logic [7:0] LastColumnReset = 8'd79;
  localparam logic [7:0] LastRowReset    = 8'd24;
  localparam logic [7:0] ColumnReset     = 8'd40;
  localparam logic [7:0] RowReset        = 8'd12;

  // apb address width: two registers at byte offsets 0 and 4
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  // register index, taken from paddr bit 2
  typedef enum logic {
    CfgLastColumn = 1'b0,
    CfgLastRow    = 1'b1
  } cfg_idx_e;

  // packet byte position
  typedef enum logic [1:0] {
    PhaseHead = 2'd0,
    PhaseDx   = 2'd1,
    PhaseDy   = 2'd2
  } phase_e;

  // one word from the controller
  typedef struct packed {
    logic [7:0] data_byte;
    logic       from_aux;
  } item_t;

  // screen bounds
  typedef struct packed {
    logic [7:0] last_column;
    logic [7:0] last_row;
  } cfg_t;

  // row * (last_column + 1) + column, kept to 16 bits
  function automatic logic [15:0] cell_of(logic [7:0] row, logic [7:0] col,
                                          logic [7:0] last_col);
    logic [8:0]  width;
    logic [16:0] prod;
    logic [16:0] sum;
    width = {1'b0, last_col} + 9'd1;
    prod  = {9'b0, row} * {8'b0, width};
    sum   = prod + {9'b0, col};
    return sum[15:0];
  endfunction

endpackage

// File: sv/ps2mpc_cfg.sv
module ps2mpc_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ps2mpc_pkg::CfgAddrW-1:0]   paddr,
  input  logic [ps2mpc_pkg::CfgDataW-1:0]   pwdata,
  output logic [ps2mpc_pkg::CfgDataW-1:0]   prdata,
  output logic                              pready,
  output ps2mpc_pkg::cfg_t                  cfg_o
);

  ps2mpc_pkg::cfg_t   cfg_q;
  ps2mpc_pkg::cfg_idx_e idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = ps2mpc_pkg::cfg_idx_e'(paddr[2]);

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.last_column <= ps2mpc_pkg::LastColumnReset;
      cfg_q.last_row    <= ps2mpc_pkg::LastRowReset;
    end else if (wr_en) begin
      unique case (idx)
        ps2mpc_pkg::CfgLastColumn: cfg_q.last_column <= pwdata[7:0];
        ps2mpc_pkg::CfgLastRow:    cfg_q.last_row    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (idx)
      ps2mpc_pkg::CfgLastColumn: prdata = {24'b0, cfg_q.last_column};
      ps2mpc_pkg::CfgLastRow:    prdata = {24'b0, cfg_q.last_row};
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/ps2mpc_in_buf.sv
module ps2mpc_in_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ps2mpc_pkg::item_t   in_item_i,
  output logic                item_valid_o,
  output ps2mpc_pkg::item_t   item_o,
  input  logic                item_take_i
);

  `include "ps2_mouse_packet_cursor_top_assert.svh"

  logic              main_valid_q, main_valid_d;
  logic              skid_valid_q, skid_valid_d;
  ps2mpc_pkg::item_t main_q, main_d;
  ps2mpc_pkg::item_t skid_q, skid_d;
  logic              accept;
  logic              main_free;

  assign accept    = in_valid_i & ~skid_valid_q;
  assign main_free = ~main_valid_q | item_take_i;

  // main register refills from the skid slot first, else from the port
  always_comb begin
    main_valid_d = main_valid_q;
    main_d       = main_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (main_free) begin
      if (skid_valid_q) begin
        main_valid_d = 1'b1;
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = accept;
        main_d       = in_item_i;
      end
    end else if (accept) begin
      skid_valid_d = 1'b1;
      skid_d       = in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign in_stall_o   = skid_valid_q;
  assign item_valid_o = main_valid_q;
  assign item_o       = main_q;

  // skid slot only fills behind a held main word
  `PS2MPC_NEVER(a_skid_without_main, skid_valid_q && !main_valid_q,
                "skid slot full while main register empty")
  `PS2MPC_NEVER(a_take_without_word, item_take_i && !main_valid_q,
                "word taken from empty input register")

endmodule

// File: sv/ps2mpc_core.sv
module ps2mpc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ps2mpc_pkg::cfg_t    cfg_i,
  input  logic                item_valid_i,
  input  ps2mpc_pkg::item_t   item_i,
  output logic                item_take_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          cursor_column_o,
  output logic [7:0]          cursor_row_o,
  output logic                left_button_o,
  output logic [15:0]         cell_index_o,
  output logic [15:0]         previous_cell_index_o
);

  `include "ps2_mouse_packet_cursor_top_assert.svh"

  ps2mpc_pkg::phase_e phase_q, phase_d;
  logic [7:0]         store_q [2];
  logic [7:0]         col_now_q, col_now_d;
  logic [7:0]         row_now_q, row_now_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         res_col_q, res_row_q, prev_col_q, prev_row_q;
  logic               res_btn_q;

  logic               final_byte;
  logic               out_free;
  logic               take;
  logic               out_load;
  logic               wr_head;
  logic               wr_dx;
  logic [7:0]         dx;
  logic [7:0]         dy;
  logic signed [8:0]  dx_adj, dy_adj;
  logic signed [7:0]  half_dx, half_dy;
  logic signed [9:0]  col_sum, row_sum;
  logic [7:0]         col_new, row_new;

  // a word that closes a packet needs room in the result register
  always_comb begin
    unique case (phase_q)
      ps2mpc_pkg::PhaseHead: final_byte = 1'b0;
      ps2mpc_pkg::PhaseDx:   final_byte = 1'b0;
      default:               final_byte = item_i.from_aux;
    endcase
  end

  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign take        = item_valid_i & (~final_byte | out_free);
  assign out_load    = take & final_byte;
  assign item_take_o = take;

  // packet assembly, non-aux words are taken and leave the phase untouched
  always_comb begin
    phase_d = phase_q;
    wr_head = 1'b0;
    wr_dx   = 1'b0;
    if (take && item_i.from_aux) begin
      unique case (phase_q)
        ps2mpc_pkg::PhaseHead: begin
          if (item_i.data_byte[3]) begin
            phase_d = ps2mpc_pkg::PhaseDx;
            wr_head = 1'b1;
          end
        end
        ps2mpc_pkg::PhaseDx: begin
          phase_d = ps2mpc_pkg::PhaseDy;
          wr_dx   = 1'b1;
        end
        default: phase_d = ps2mpc_pkg::PhaseHead;
      endcase
    end
  end

  // halve deltas, rounding toward zero
  assign dx      = store_q[1];
  assign dy      = item_i.data_byte;
  assign dx_adj  = $signed({dx[7], dx}) + $signed({8'b0, dx[7]});
  assign dy_adj  = $signed({dy[7], dy}) + $signed({8'b0, dy[7]});
  assign half_dx = dx_adj[8:1];
  assign half_dy = dy_adj[8:1];

  // move and clamp
  assign col_sum = $signed({2'b0, col_now_q}) + $signed({{2{half_dx[7]}}, half_dx});
  assign row_sum = $signed({2'b0, row_now_q}) - $signed({{2{half_dy[7]}}, half_dy});

  always_comb begin
    if (col_sum[9]) begin
      col_new = 8'd0;
    end else if (col_sum[8:0] > {1'b0, cfg_i.last_column}) begin
      col_new = cfg_i.last_column;
    end else begin
      col_new = col_sum[7:0];
    end
    if (row_sum[9]) begin
      row_new = 8'd0;
    end else if (row_sum[8:0] > {1'b0, cfg_i.last_row}) begin
      row_new = cfg_i.last_row;
    end else begin
      row_new = row_sum[7:0];
    end
  end

  assign col_now_d   = out_load ? col_new : col_now_q;
  assign row_now_d   = out_load ? row_new : row_now_q;
  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  // control and cursor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ps2mpc_pkg::PhaseHead;
      col_now_q   <= ps2mpc_pkg::ColumnReset;
      row_now_q   <= ps2mpc_pkg::RowReset;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      col_now_q   <= col_now_d;
      row_now_q   <= row_now_d;
      out_valid_q <= out_valid_d;
    end
  end

  // packet bytes and result payload
  always_ff @(posedge clk_i) begin
    if (wr_head) begin
      store_q[0] <= item_i.data_byte;
    end
    if (wr_dx) begin
      store_q[1] <= item_i.data_byte;
    end
    if (out_load) begin
      res_col_q  <= col_new;
      res_row_q  <= row_new;
      res_btn_q  <= store_q[0][0];
      prev_col_q <= col_now_q;
      prev_row_q <= row_now_q;
    end
  end

  // cell indexes use the live column bound
  assign out_valid_o           = out_valid_q;
  assign cursor_column_o       = res_col_q;
  assign cursor_row_o          = res_row_q;
  assign left_button_o         = res_btn_q;
  assign cell_index_o          = ps2mpc_pkg::cell_of(res_row_q, res_col_q, cfg_i.last_column);
  assign previous_cell_index_o = ps2mpc_pkg::cell_of(prev_row_q, prev_col_q,
                                                     cfg_i.last_column);

  `PS2MPC_NEVER(a_phase_unused, phase_q == 2'd3, "packet phase reached unused code")
  `PS2MPC_NEVER(a_load_over_held, out_load && out_valid_q && out_stall_i,
                "result overwritten while stalled")
  `PS2MPC_ASSERT(a_col_in_bounds, out_load |=> res_col_q <= $past(cfg_i.last_column),
                 "new column beyond last column")
  `PS2MPC_ASSERT(a_row_in_bounds, out_load |=> res_row_q <= $past(cfg_i.last_row),
                 "new row beyond last row")
  `PS2MPC_ASSERT(a_phase_holds, !take |=> phase_q == $past(phase_q),
                 "packet phase moved without a word")

endmodule

// File: sv/ps2_mouse_packet_cursor_top.sv
// a packet result passes through the input register, then the result register
// throughput: one byte per cycle while in_stall_o is low; the result register frees in the cycle it is taken
// a two-entry input buffer keeps in_stall_o registered; it rises after a held result
// reset: async active low; cursor at column 40 row 12, packet phase at
// the first byte, last_column 79, last_row 24; no clearing pass is needed
module ps2_mouse_packet_cursor_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // apb configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ps2mpc_pkg::CfgAddrW-1:0]   paddr,
  input  logic [ps2mpc_pkg::CfgDataW-1:0]   pwdata,
  output logic [ps2mpc_pkg::CfgDataW-1:0]   prdata,
  output logic                              pready,
  // controller bytes
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        data_byte_i,
  input  logic                              from_aux_i,
  // cursor results
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [7:0]                        cursor_column_o,
  output logic [7:0]                        cursor_row_o,
  output logic                              left_button_o,
  output logic [15:0]                       cell_index_o,
  output logic [15:0]                       previous_cell_index_o
);

  ps2mpc_pkg::cfg_t  cfg;
  ps2mpc_pkg::item_t in_item;
  ps2mpc_pkg::item_t item;
  logic              item_valid;
  logic              item_take;

  assign in_item.data_byte = data_byte_i;
  assign in_item.from_aux  = from_aux_i;

  // configuration registers
  ps2mpc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register with skid slot
  ps2mpc_in_buf u_in_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  // packet decode, cursor update and result register
  ps2mpc_core u_core (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_i                 (cfg),
    .item_valid_i          (item_valid),
    .item_i                (item),
    .item_take_o           (item_take),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .cursor_column_o       (cursor_column_o),
    .cursor_row_o          (cursor_row_o),
    .left_button_o         (left_button_o),
    .cell_index_o          (cell_index_o),
    .previous_cell_index_o (previous_cell_index_o)
  );

endmodule

// File: test/testbench.sv
module testbench;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 80;
  localparam int DrainCycles = 8;

  // one cursor word as the block reports it
  typedef struct packed {
    logic [7:0]  column;
    logic [7:0]  row;
    logic        button;
    logic [15:0] cell_idx;
    logic [15:0] prev_idx;
  } cursor_t;

  // directed stimulus row; typed rows carry the cursor word read off by hand
  typedef struct packed {
    logic [7:0] data_byte;
    logic       aux;
    logic       typed;
    cursor_t    want;
  } stim_row_t;

  // per-word note that travels with the item to its acceptance
  typedef struct packed {
    logic    typed;
    cursor_t want;
  } note_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [ps2mpc_pkg::CfgAddrW-1:0] paddr = '0;
  logic [ps2mpc_pkg::CfgDataW-1:0] pwdata = '0;
  logic [ps2mpc_pkg::CfgDataW-1:0] prdata;
  logic                            pready;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic [7:0]                      data_byte_i = '0;
  logic                            from_aux_i = 1'b0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [7:0]                      cursor_column_o;
  logic [7:0]                      cursor_row_o;
  logic                            left_button_o;
  logic [15:0]                     cell_index_o;
  logic [15:0]                     previous_cell_index_o;

  ps2_mouse_packet_cursor_top i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .data_byte_i           (data_byte_i),
    .from_aux_i            (from_aux_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .cursor_column_o       (cursor_column_o),
    .cursor_row_o          (cursor_row_o),
    .left_button_o         (left_button_o),
    .cell_index_o          (cell_index_o),
    .previous_cell_index_o (previous_cell_index_o)
  );

  always #5 clk_i = ~clk_i;

  // mirror of the decoder state and the screen bounds
  logic [7:0]         scr_last_col = ps2mpc_pkg::LastColumnReset;
  logic [7:0]         scr_last_row = ps2mpc_pkg::LastRowReset;
  ps2mpc_pkg::phase_e pkt_phase = ps2mpc_pkg::PhaseHead;
  logic [7:0]         head_byte = '0;
  logic [7:0]         dx_byte = '0;
  logic [7:0]         cur_col = ps2mpc_pkg::ColumnReset;
  logic [7:0]         cur_row = ps2mpc_pkg::RowReset;
  logic               cur_button = 1'b0;

  cursor_t expect_q[$];
  note_t   note_q[$];

  int mismatches = 0;
  int words_taken = 0;
  int cursors_seen = 0;
  int bound_writes = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  // directed words: noise, resync drops, then packets hitting both clamps,
  // truncation toward zero and a non-aux word inside a packet
  stim_row_t directed_rows [0:21] = '{
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'hF7, 1'b1, 1'b0, '0},
    '{8'h09, 1'b1, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, '{8'd40, 8'd12, 1'b1, 16'd1000, 16'd1000}},
    '{8'h08, 1'b1, 1'b0, '0},
    '{8'h7F, 1'b1, 1'b0, '0},
    '{8'h80, 1'b1, 1'b1, '{8'd79, 8'd24, 1'b0, 16'd1999, 16'd1000}},
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'h55, 1'b0, 1'b0, '0},
    '{8'h80, 1'b1, 1'b0, '0},
    '{8'h7F, 1'b1, 1'b1, '{8'd15, 8'd0, 1'b1, 16'd15, 16'd1999}},
    '{8'h0A, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'h01, 1'b1, 1'b1, '{8'd15, 8'd0, 1'b0, 16'd15, 16'd15}},
    '{8'h08, 1'b1, 1'b0, '0},
    '{8'h03, 1'b1, 1'b0, '0},
    '{8'hFD, 1'b1, 1'b1, '{8'd16, 8'd1, 1'b0, 16'd96, 16'd15}},
    '{8'h3C, 1'b1, 1'b0, '0},
    '{8'h80, 1'b1, 1'b0, '0},
    '{8'h80, 1'b1, 1'b1, '{8'd0, 8'd24, 1'b0, 16'd1920, 16'd96}}
  };

  // row * screen width + column, wrapped to 16 bits
  function automatic logic [15:0] cell_number(logic [7:0] r, logic [7:0] c);
    int unsigned w;
    w = int'(scr_last_col) + 1;
    return 16'(int'(r) * w + int'(c));
  endfunction

  // feed one controller word through the packet decoder
  function automatic void decode_word(input logic [7:0] b, input logic aux,
                                      output bit produced, output cursor_t res);
    int dx;
    int dy;
    int col;
    int row;
    logic [15:0] prev;
    produced = 1'b0;
    res = '0;
    if (!aux) return;
    // first byte must carry the always-one bit or it is dropped
    if (pkt_phase == ps2mpc_pkg::PhaseHead && !b[3]) return;
    if (pkt_phase == ps2mpc_pkg::PhaseHead) begin
      head_byte = b;
      pkt_phase = ps2mpc_pkg::PhaseDx;
      return;
    end
    if (pkt_phase == ps2mpc_pkg::PhaseDx) begin
      dx_byte = b;
      pkt_phase = ps2mpc_pkg::PhaseDy;
      return;
    end
    pkt_phase = ps2mpc_pkg::PhaseHead;
    prev = cell_number(cur_row, cur_col);
    dx = int'($signed(dx_byte)) / 2;
    dy = int'($signed(b)) / 2;
    cur_button = head_byte[0];
    col = int'(cur_col) + dx;
    row = int'(cur_row) - dy;
    if (col < 0) col = 0;
    if (col > int'(scr_last_col)) col = int'(scr_last_col);
    if (row < 0) row = 0;
    if (row > int'(scr_last_row)) row = int'(scr_last_row);
    cur_col = 8'(col);
    cur_row = 8'(row);
    res.column = cur_col;
    res.row = cur_row;
    res.button = cur_button;
    res.cell_idx = cell_number(cur_row, cur_col);
    res.prev_idx = prev;
    produced = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // acceptance of controller words and checking of cursor words
  always @(posedge clk_i) begin
    bit produced;
    cursor_t predicted;
    cursor_t want;
    note_t note;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        note = note_q.pop_front();
        decode_word(data_byte_i, from_aux_i, produced, predicted);
        if (produced) expect_q.push_back(note.typed ? note.want : predicted);
        words_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        cursors_seen++;
        if (expect_q.size() == 0) begin
          $error("cursor word with nothing expected: column %0d row %0d",
                 cursor_column_o, cursor_row_o);
          mismatches++;
        end else begin
          want = expect_q.pop_front();
          check_field("cursor_column", want.column, cursor_column_o);
          check_field("cursor_row", want.row, cursor_row_o);
          check_field("left_button", want.button, left_button_o);
          check_field("cell_index", want.cell_idx, cell_index_o);
          check_field("previous_cell_index", want.prev_idx, previous_cell_index_o);
        end
      end
    end
  end

  // receiver: random stall, or a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_asked != hold_served) begin
      hold_served <= hold_asked;
      hold_left <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // offer one word and hold it until taken; valid stays up afterwards
  task automatic send_word(input logic [7:0] b, input logic aux, input logic typed,
                           input cursor_t want);
    note_t note;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    note.typed = typed;
    note.want = want;
    note_q.push_back(note);
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    from_aux_i <= aux;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // mostly small moves so the cursor wanders, sometimes the full byte range
  function automatic logic [7:0] pick_delta();
    if ($urandom_range(0, 3) == 0) return 8'($urandom());
    return 8'($urandom_range(0, 40)) - 8'd20;
  endfunction

  // a non-aux word slipped between packet bytes now and then
  task automatic maybe_noise();
    if ($urandom_range(0, 9) == 0) send_word(8'($urandom()), 1'b0, 1'b0, '0);
  endtask

  // well-formed packet, lone non-aux word or stray aux byte
  task automatic send_random(output int aux_words);
    logic [7:0] head;
    int pick;
    pick = $urandom_range(0, 9);
    aux_words = 0;
    if (pick < 8) begin
      head = 8'($urandom());
      head[3] = 1'b1;
      send_word(head, 1'b1, 1'b0, '0);
      maybe_noise();
      send_word(pick_delta(), 1'b1, 1'b0, '0);
      maybe_noise();
      send_word(pick_delta(), 1'b1, 1'b0, '0);
      aux_words = 3;
    end else if (pick == 8) begin
      send_word(8'($urandom()), 1'b0, 1'b0, '0);
    end else begin
      send_word(8'($urandom()), 1'b1, 1'b0, '0);
      aux_words = 1;
    end
  endtask

  // stop offering and let every expected cursor word drain
  task automatic settle();
    in_valid_i <= 1'b0;
    // let the monitor see the word taken at this edge first
    @(posedge clk_i);
    while (expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // apb write of one bound, then read it back
  task automatic write_bound(input ps2mpc_pkg::cfg_idx_e idx, input logic [7:0] value);
    logic [ps2mpc_pkg::CfgDataW-1:0] back;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'($urandom()), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == ps2mpc_pkg::CfgLastColumn) scr_last_col = value;
    else scr_last_row = value;
    bound_writes++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    back = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    // bus idle between transfers
    @(posedge clk_i);
    check_field(idx == ps2mpc_pkg::CfgLastColumn ? "last_column readback"
                                                 : "last_row readback",
                value, back[7:0]);
  endtask

  // one stretch of random traffic under one screen size and idling mix
  task automatic run_phase(input int words, input int idle_pct, input int stall,
                           input logic [7:0] last_col, input logic [7:0] last_row,
                           input bit hold_off, input bit split_packet);
    int sent;
    int got;
    sent = 0;
    // a packet head left open across the bound change
    if (split_packet) send_word(8'h08 | 8'($urandom()), 1'b1, 1'b0, '0);
    settle();
    write_bound(ps2mpc_pkg::CfgLastColumn, last_col);
    write_bound(ps2mpc_pkg::CfgLastRow, last_row);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    if (hold_off) hold_asked++;
    while (sent < words) begin
      send_random(got);
      sent += got;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].data_byte, directed_rows[i].aux,
                directed_rows[i].typed, directed_rows[i].want);
    end

    run_phase(80, 0, 0, ps2mpc_pkg::LastColumnReset, ps2mpc_pkg::LastRowReset,
              1'b0, 1'b0);
    run_phase(80, 83, 0, 8'd255, 8'd255, 1'b0, 1'b1);
    // cursor left far outside the shrunken screen until the next packet
    run_phase(80, 0, 83, 8'd1, 8'd1, 1'b0, 1'b0);
    run_phase(80, 37, 37, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
              1'b0, 1'b1);
    run_phase(80, 0, 0, 8'($urandom_range(1, 255)), 8'd255, 1'b1, 1'b0);
    run_phase(30, 37, 37, 8'd0, 8'd0, 1'b0, 1'b0);
    run_phase(50, 0, 0, 8'd255, 8'd1, 1'b0, 1'b1);
    settle();

    $display("summary: %0d controller words taken, %0d cursor words checked,",
             words_taken, cursors_seen);
    $display("summary: %0d bound writes across seven screen sizes and idling mixes",
             bound_writes);
    if (mismatches == 0 && expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: ps2_mouse_packet_cursor_top.f
+incdir+sv
sv/ps2mpc_pkg.sv
sv/ps2mpc_cfg.sv
sv/ps2mpc_in_buf.sv
sv/ps2mpc_core.sv
sv/ps2_mouse_packet_cursor_top.sv
test/testbench.sv
